// File: rtl/fbd_pkg.sv
// Shared types and constants for the four-button press debouncer.
// Used by fbd_button and four_button_press_debouncer_top; depends on nothing.
package fbd_pkg;

	// Width of the millisecond timestamp and of the stored phase stamps.
	localparam int unsigned STAMP_WIDTH = 32;
	// Width of each settle-time register.
	localparam int unsigned SETTLE_WIDTH = 16;
	// Width of the configuration register index.
	localparam int unsigned CFG_INDEX_WIDTH = 2;

	// Reset values of the settle-time registers.
	localparam logic [SETTLE_WIDTH-1:0] PRESS_SETTLE_RESET = 16'd20;
	localparam logic [SETTLE_WIDTH-1:0] RELEASE_SETTLE_RESET = 16'd10;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_SETTLE = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_SETTLE = 2'd1;

	// Phase of one button's debounce machine.
	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_PRESS_DEB,
		PHASE_HELD,
		PHASE_RELEASE_DEB
	} phase_t;

	// Settle times shared by all button machines.
	typedef struct packed {
		logic [SETTLE_WIDTH-1:0] press_ms;
		logic [SETTLE_WIDTH-1:0] release_ms;
	} settle_cfg_t;

endpackage

// File: rtl/fbd_button.sv
// Debounce state machine for a single button: phase and phase stamp registers.
// Depends on fbd_pkg for the phase type, the settle configuration and widths.
module fbd_button (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_en,
	input  logic                                level,
	input  logic [fbd_pkg::STAMP_WIDTH-1:0]     now,
	input  fbd_pkg::settle_cfg_t                settle,
	output logic                                fire
);

	fbd_pkg::phase_t                    phase_q;
	fbd_pkg::phase_t                    phase_next;
	logic [fbd_pkg::STAMP_WIDTH-1:0]    stamp_q;
	logic [fbd_pkg::STAMP_WIDTH-1:0]    elapsed;
	logic                               press_done;
	logic                               release_done;
	logic                               stamp_load;

	// Elapsed time wraps modulo 2^32, so a plain subtraction is enough.
	assign elapsed = now - stamp_q;
	assign press_done = elapsed >=
		{{(fbd_pkg::STAMP_WIDTH - fbd_pkg::SETTLE_WIDTH){1'b0}}, settle.press_ms};
	assign release_done = elapsed >=
		{{(fbd_pkg::STAMP_WIDTH - fbd_pkg::SETTLE_WIDTH){1'b0}}, settle.release_ms};

	// Next phase. The release debounce ignores the pin level.
	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			fbd_pkg::PHASE_IDLE: begin
				if (!level) phase_next = fbd_pkg::PHASE_PRESS_DEB;
			end
			fbd_pkg::PHASE_PRESS_DEB: begin
				if (level) phase_next = fbd_pkg::PHASE_IDLE;
				else if (press_done) phase_next = fbd_pkg::PHASE_HELD;
			end
			fbd_pkg::PHASE_HELD: begin
				if (level) phase_next = fbd_pkg::PHASE_RELEASE_DEB;
			end
			fbd_pkg::PHASE_RELEASE_DEB: begin
				if (release_done) phase_next = fbd_pkg::PHASE_IDLE;
			end
			default: begin
				phase_next = fbd_pkg::PHASE_IDLE;
			end
		endcase
	end

	// Outputs: the press report and the stamp load on entry to a debounce phase.
	always_comb begin
		fire = 1'b0;
		stamp_load = 1'b0;
		case (phase_q)
			fbd_pkg::PHASE_IDLE: begin
				stamp_load = !level;
			end
			fbd_pkg::PHASE_PRESS_DEB: begin
				fire = !level && press_done;
			end
			fbd_pkg::PHASE_HELD: begin
				stamp_load = level;
			end
			default: begin
				fire = 1'b0;
			end
		endcase
	end

	// State registers advance once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fbd_pkg::PHASE_IDLE;
			stamp_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_next;
			if (stamp_load) stamp_q <= now;
		end
	end

endmodule

// File: rtl/four_button_press_debouncer_top.sv
// Top level of the button press debouncer: input stage, button machines,
// press latch and output register. Depends on fbd_pkg and fbd_button.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick: now_ms, pin_levels
//   (active low, one bit per button) and take_press. Output channel
//   (out_valid/out_ready) returns one pressed_code per tick: the latched
//   button number after that tick, or BUTTON_COUNT when nothing is latched.
//   A set take_press clears the latch after the code of its own tick.
//   The configuration port writes press_settle_ms (index 0) and
//   release_settle_ms (index 1) on any cycle with cfg_wr_en high; other
//   indexes are ignored. Write only while the block is idle.
// Timing:
//   A transferred tick is registered in the input stage; once the output
//   register is free or being emptied, the button machines process it and its
//   code is registered in the output register. One tick per cycle is sustained
//   while the receiver is ready; the rate is set by the phase update of the
//   button machines.
// Reset and stalls:
//   Reset puts every button in idle, clears the latch to none and restores
//   the settle times to 20 ms and 10 ms. While the receiver stalls, the
//   output register holds its code; the input stage can still take one tick,
//   and in_ready drops only once both stages are full.
module four_button_press_debouncer_top #(
	parameter int unsigned BUTTON_COUNT = 4
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [fbd_pkg::STAMP_WIDTH-1:0]            now_ms,
	input  logic [BUTTON_COUNT-1:0]                    pin_levels,
	input  logic                                       take_press,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [$clog2(BUTTON_COUNT+1)-1:0]          pressed_code,
	input  logic                                       cfg_wr_en,
	input  logic [fbd_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
	input  logic [fbd_pkg::SETTLE_WIDTH-1:0]           cfg_data
);

	localparam int unsigned CODE_WIDTH = $clog2(BUTTON_COUNT + 1);
	localparam logic [CODE_WIDTH-1:0] NO_PRESS = CODE_WIDTH'(BUTTON_COUNT);

	fbd_pkg::settle_cfg_t               settle_q;
	logic                               valid_s1;
	logic [fbd_pkg::STAMP_WIDTH-1:0]    now_s1;
	logic [BUTTON_COUNT-1:0]            pins_s1;
	logic                               take_s1;
	logic                               out_free;
	logic                               step_s1;
	logic [BUTTON_COUNT-1:0]            fire;
	logic [CODE_WIDTH-1:0]              latch_q;
	logic [CODE_WIDTH-1:0]              latch_next;
	logic                               out_valid_q;
	logic [CODE_WIDTH-1:0]              code_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q.press_ms <= fbd_pkg::PRESS_SETTLE_RESET;
			settle_q.release_ms <= fbd_pkg::RELEASE_SETTLE_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == fbd_pkg::CFG_PRESS_SETTLE) settle_q.press_ms <= cfg_data;
			if (cfg_index == fbd_pkg::CFG_RELEASE_SETTLE) settle_q.release_ms <= cfg_data;
		end
	end

	// Handshake: the tick in the input stage is processed when the output
	// register is free or being emptied.
	assign out_free = !out_valid_q || out_ready;
	assign step_s1 = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1 <= now_ms;
			pins_s1 <= pin_levels;
			take_s1 <= take_press;
		end
	end

	// One debounce machine per button.
	for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_button
		fbd_button u_button (
			.clk     (clk),
			.arst_n  (arst_n),
			.step_en (step_s1),
			.level   (pins_s1[g]),
			.now     (now_s1),
			.settle  (settle_q),
			.fire    (fire[g])
		);
	end

	// The highest button that reports a press in this tick wins the latch.
	always_comb begin
		latch_next = latch_q;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (fire[i]) latch_next = CODE_WIDTH'(i);
		end
	end

	// Press latch; a take clears it after this tick's code is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= NO_PRESS;
		end else if (step_s1) begin
			latch_q <= take_s1 ? NO_PRESS : latch_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1) code_q <= latch_next;
	end

	assign out_valid = out_valid_q;
	assign pressed_code = code_q;

`ifndef SYNTH
	// A shown code is a button number or the none code.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (code_q <= NO_PRESS))
		else $error("pressed_code out of range");

	// A processed tick always produces a result on the next cycle.
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_s1 |=> out_valid_q)
		else $error("processed tick did not produce a result");

	// A take leaves the latch empty.
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_s1 && take_s1) |=> (latch_q == NO_PRESS))
		else $error("latch not cleared after take");

	// With both stages full and the receiver stalled, no tick is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full");
`endif

endmodule

// File: tb/tb.sv
// Testbench for four_button_press_debouncer_top: directed and random ticks, with a
// tick-level predictor of the four button machines and the press latch.
// Depends on fbd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned BUTTONS = 4;
	localparam logic [2:0] NO_PRESS_CODE = 3'd4;
	// Register indexes that the block must ignore.
	localparam logic [fbd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [fbd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_B = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned MAX_PRINTED = 40;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_LONG_STALLS
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [fbd_pkg::STAMP_WIDTH-1:0] now_ms;
	logic [BUTTONS-1:0] pin_levels;
	logic take_press;
	logic out_valid;
	logic out_ready;
	logic [2:0] pressed_code;
	logic cfg_wr_en;
	logic [fbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [fbd_pkg::SETTLE_WIDTH-1:0] cfg_data;

	// Predictor state.
	fbd_pkg::phase_t button_state [BUTTONS];
	logic [fbd_pkg::STAMP_WIDTH-1:0] button_stamp [BUTTONS];
	logic [2:0] latched_button;
	fbd_pkg::settle_cfg_t settle_times;
	logic [2:0] expected_codes [$];

	int mismatch_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit sender_gaps_on = 1'b0;
	rx_mode_t rx_mode = RX_ALWAYS;
	logic [7:0] rx_count = '0;
	int rx_hold = 0;
	logic rx_level = 1'b1;

	four_button_press_debouncer_top #(
		.BUTTON_COUNT(BUTTONS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.pin_levels(pin_levels),
		.take_press(take_press),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pressed_code(pressed_code),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a period of 8 ns.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED) begin
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// Puts the predictor into its post-reset state.
	task automatic reset_debounce_model();
		int b;
		for (b = 0; b < BUTTONS; b++) begin
			button_state[b] = fbd_pkg::PHASE_IDLE;
			button_stamp[b] = '0;
		end
		latched_button = NO_PRESS_CODE;
		settle_times.press_ms = fbd_pkg::PRESS_SETTLE_RESET;
		settle_times.release_ms = fbd_pkg::RELEASE_SETTLE_RESET;
	endtask

	// Advances every button machine by one tick and queues the code that results.
	task automatic predict_pressed_code(input logic [fbd_pkg::STAMP_WIDTH-1:0] t,
			input logic [BUTTONS-1:0] pins, input logic take);
		int b;
		logic [fbd_pkg::STAMP_WIDTH-1:0] elapsed;
		for (b = 0; b < BUTTONS; b++) begin
			elapsed = t - button_stamp[b];
			case (button_state[b])
				fbd_pkg::PHASE_IDLE: begin
					if (!pins[b]) begin
						button_state[b] = fbd_pkg::PHASE_PRESS_DEB;
						button_stamp[b] = t;
					end
				end
				fbd_pkg::PHASE_PRESS_DEB: begin
					if (pins[b]) begin
						button_state[b] = fbd_pkg::PHASE_IDLE;
					end else if (elapsed >=
							fbd_pkg::STAMP_WIDTH'(settle_times.press_ms)) begin
						// Ascending order lets a higher button overwrite a lower one.
						latched_button = 3'(b);
						button_state[b] = fbd_pkg::PHASE_HELD;
					end
				end
				fbd_pkg::PHASE_HELD: begin
					if (pins[b]) begin
						button_state[b] = fbd_pkg::PHASE_RELEASE_DEB;
						button_stamp[b] = t;
					end
				end
				default: begin
					// The pin is not looked at while the release settles.
					if (elapsed >= fbd_pkg::STAMP_WIDTH'(settle_times.release_ms)) begin
						button_state[b] = fbd_pkg::PHASE_IDLE;
					end
				end
			endcase
		end
		expected_codes.push_back(latched_button);
		if (take) begin
			latched_button = NO_PRESS_CODE;
		end
	endtask

	// Sends one tick, with a random gap at the start of each burst when sender gaps are on.
	task automatic send_tick(input logic [fbd_pkg::STAMP_WIDTH-1:0] t,
			input logic [BUTTONS-1:0] pins, input logic take);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_gaps_on) begin
				gap = $urandom_range(0, 6);
			end
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		pin_levels <= pins;
		take_press <= take;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_pressed_code(t, pins, take);
	endtask

	// Stops sending and waits until every queued code has been checked.
	task automatic wait_results_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	// Writes one register; only called while the block is idle.
	task automatic cfg_write(input logic [fbd_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [fbd_pkg::SETTLE_WIDTH-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == fbd_pkg::CFG_PRESS_SETTLE) begin
			settle_times.press_ms = value;
		end else if (idx == fbd_pkg::CFG_RELEASE_SETTLE) begin
			settle_times.release_ms = value;
		end
	endtask

	// One button through every phase with the reset settle times.
	task automatic test_default_press();
		sender_gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		send_tick(32'd0, 4'hF, 1'b0);
		send_tick(32'd1, 4'hE, 1'b0);
		send_tick(32'd10, 4'hE, 1'b0);
		send_tick(32'd21, 4'hE, 1'b0);
		send_tick(32'd22, 4'hF, 1'b1);
		send_tick(32'd31, 4'hF, 1'b0);
		send_tick(32'd32, 4'hF, 1'b0);
	endtask

	// A press that bounces back high before settling is never reported.
	task automatic test_press_bounce();
		rx_mode = RX_RANDOM;
		send_tick(32'd100, 4'hD, 1'b0);
		send_tick(32'd115, 4'hD, 1'b0);
		send_tick(32'd116, 4'hF, 1'b0);
		send_tick(32'd140, 4'hF, 1'b0);
	endtask

	// All buttons settle in the same tick; the highest number wins.
	task automatic test_simultaneous_press();
		sender_gaps_on = 1'b1;
		send_tick(32'd200, 4'h0, 1'b0);
		send_tick(32'd225, 4'h0, 1'b1);
		send_tick(32'd226, 4'hF, 1'b0);
		send_tick(32'd240, 4'hF, 1'b0);
	endtask

	// Zero and maximum settle times across the timestamp wrap, and ignored indexes.
	task automatic test_zero_and_max_settle();
		wait_results_done();
		cfg_write(fbd_pkg::CFG_PRESS_SETTLE, 16'h0000);
		cfg_write(fbd_pkg::CFG_RELEASE_SETTLE, 16'h0000);
		cfg_write(CFG_UNUSED_A, 16'hFFFF);
		cfg_write(CFG_UNUSED_B, 16'h0001);
		// With zero settle time a debounce still ends one tick after it starts.
		send_tick(32'hFFFF_FFFE, 4'h7, 1'b0);
		send_tick(32'hFFFF_FFFE, 4'h7, 1'b0);
		send_tick(32'hFFFF_FFFF, 4'hF, 1'b1);
		send_tick(32'h0000_0000, 4'hF, 1'b0);
		wait_results_done();
		cfg_write(fbd_pkg::CFG_PRESS_SETTLE, 16'hFFFF);
		cfg_write(fbd_pkg::CFG_RELEASE_SETTLE, 16'hFFFF);
		send_tick(32'hFFFF_FFF0, 4'hB, 1'b0);
		send_tick(32'h0000_FFEE, 4'hB, 1'b0);
		send_tick(32'h0000_FFEF, 4'hB, 1'b1);
		send_tick(32'h0001_0000, 4'hF, 1'b0);
		send_tick(32'h0002_0000, 4'hF, 1'b0);
	endtask

	// Phases of random press sequences with bounces and noise, new settings between phases.
	task automatic test_random_traffic();
		logic [fbd_pkg::STAMP_WIDTH-1:0] t;
		logic [BUTTONS-1:0] intent;
		logic [BUTTONS-1:0] pins;
		int phase;
		int n;
		int b;
		int r;
		t = $urandom;
		intent = '0;
		for (phase = 0; phase < 8; phase++) begin
			// The sender pauses here until every code has come back.
			wait_results_done();
			r = $urandom_range(0, 9);
			if (phase == 1 || r == 0) begin
				cfg_write(fbd_pkg::CFG_PRESS_SETTLE, 16'h0000);
				cfg_write(fbd_pkg::CFG_RELEASE_SETTLE, 16'h0000);
			end else if (r == 1) begin
				cfg_write(fbd_pkg::CFG_PRESS_SETTLE, 16'hFFFF);
				cfg_write(fbd_pkg::CFG_RELEASE_SETTLE, 16'($urandom_range(0, 65535)));
			end else begin
				cfg_write(fbd_pkg::CFG_PRESS_SETTLE, 16'($urandom_range(0, 30)));
				cfg_write(fbd_pkg::CFG_RELEASE_SETTLE, 16'($urandom_range(0, 30)));
			end
			if ($urandom_range(0, 3) == 0) begin
				cfg_write($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
					16'($urandom));
			end
			sender_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			rx_mode = (phase == 0) ? RX_ALWAYS : rx_mode_t'($urandom_range(0, 3));
			if (phase == 4) begin
				t = 32'hFFFF_FF00 | fbd_pkg::STAMP_WIDTH'($urandom_range(0, 255));
			end
			for (n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					// Noise: a random jump in time and random pin levels.
					t = $urandom;
					pins = BUTTONS'($urandom);
				end else begin
					if (r < 8) begin
						t = t + fbd_pkg::STAMP_WIDTH'($urandom_range(0, 70000));
					end else if (r < 25) begin
						t = t + fbd_pkg::STAMP_WIDTH'($urandom_range(0, 40));
					end else begin
						t = t + fbd_pkg::STAMP_WIDTH'($urandom_range(0, 6));
					end
					for (b = 0; b < BUTTONS; b++) begin
						if ($urandom_range(0, 11) == 0) begin
							intent[b] = ~intent[b];
						end
					end
					pins = ~intent;
					// Occasional contact bounce on one pin.
					if ($urandom_range(0, 14) == 0) begin
						b = $urandom_range(0, BUTTONS - 1);
						pins[b] = ~pins[b];
					end
				end
				send_tick(t, pins, $urandom_range(0, 3) == 0);
			end
		end
	endtask

	// Receiver stall pattern, chosen per phase.
	always @(negedge clk) begin
		rx_count <= rx_count + 8'd1;
		case (rx_mode)
			RX_ALWAYS: begin
				out_ready <= 1'b1;
			end
			RX_RANDOM: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			RX_PERIODIC: begin
				out_ready <= (rx_count[2:0] < 3'd5);
			end
			default: begin
				if (rx_hold == 0) begin
					rx_level = ~rx_level;
					rx_hold = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 30);
				end else begin
					rx_hold--;
				end
				out_ready <= rx_level;
			end
		endcase
	end

	// Compares each result transfer with the oldest expected code.
	always @(posedge clk) begin
		logic [2:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("code %0d with nothing expected", pressed_code));
			end else begin
				want = expected_codes.pop_front();
				if (pressed_code !== want) begin
					report_mismatch($sformatf("pressed_code %0d, expected %0d",
						pressed_code, want));
				end
			end
		end
	end

	// Ends the run if no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		now_ms = '0;
		pin_levels = '1;
		take_press = 1'b0;
		out_ready = 1'b1;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_debounce_model();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_default_press();
		test_press_bounce();
		test_simultaneous_press();
		test_zero_and_max_settle();
		test_random_traffic();
		wait_results_done();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/fbd_pkg.sv
rtl/fbd_button.sv
rtl/four_button_press_debouncer_top.sv
tb/tb.sv
